/* rtl/sos_pkg.sv */
// Shared widths, constants and control types of the supply outage statistics block.
`timescale 1ns / 1ps

package sos_pkg;

    localparam int TIME_W = 32;
    localparam int FLOW_W = 32;
    localparam int TOL_W  = 31;
    localparam int LOST_W = 63;
    localparam int SERV_W = 64;

    localparam logic [TOL_W-1:0]         GAP_TOL_RESET = 31'd66;
    localparam logic [LOST_W-1:0]        UNSERVED_MAX  = {LOST_W{1'b1}};
    localparam logic signed [SERV_W-1:0] SERVED_MAX    = {1'b0, {(SERV_W-1){1'b1}}};
    localparam logic signed [SERV_W-1:0] SERVED_MIN    = {1'b1, {(SERV_W-1){1'b0}}};

    // Per-beat control that travels alongside the data through the pipe.
    typedef struct packed {
        logic apply;  // interval is judged and accumulated
        logic clr;    // statistics are cleared before this beat is applied
        logic err;    // nonzero sample time did not increase
    } t_ctl;

endpackage

/* rtl/sos_front.sv */
// Input stage: held sample state, interval length, flow gap and order check.
`timescale 1ns / 1ps

module sos_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sos_pkg::TOL_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sos_pkg::TIME_W-1:0]          i_sample_time,
    input  logic signed [sos_pkg::FLOW_W-1:0]   i_requested_flow,
    input  logic signed [sos_pkg::FLOW_W-1:0]   i_achieved_flow,
    input  logic                                i_series_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sos_pkg::TIME_W-1:0]          o_dt,
    output logic [sos_pkg::FLOW_W-1:0]          o_gap,
    output logic signed [sos_pkg::FLOW_W-1:0]   o_held_ach,
    output sos_pkg::t_ctl                       o_ctl,
    output logic [sos_pkg::TOL_W-1:0]           o_gap_tolerance
);

    logic [sos_pkg::TOL_W-1:0]          r_gap_tolerance;
    logic [sos_pkg::TIME_W-1:0]         r_prev_time, n_prev_time;
    logic signed [sos_pkg::FLOW_W-1:0]  r_held_req, n_held_req;
    logic signed [sos_pkg::FLOW_W-1:0]  r_held_ach, n_held_ach;

    logic                               r_valid;
    logic [sos_pkg::TIME_W-1:0]         r_dt;
    logic [sos_pkg::FLOW_W-1:0]         r_gap;
    logic signed [sos_pkg::FLOW_W-1:0]  r_out_ach;
    sos_pkg::t_ctl                      r_ctl;

    logic                               accept;
    logic [sos_pkg::TIME_W-1:0]         prev_base;
    logic signed [sos_pkg::FLOW_W-1:0]  req_base;
    logic signed [sos_pkg::FLOW_W-1:0]  ach_base;
    logic signed [sos_pkg::FLOW_W:0]    diff;
    logic signed [sos_pkg::FLOW_W:0]    diff_neg;
    logic [sos_pkg::FLOW_W-1:0]         gap;
    logic                               time_zero;
    logic                               late;
    logic                               apply;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // A series start clears the held state before the sample is judged.
    assign prev_base = i_series_start ? '0 : r_prev_time;
    assign req_base  = i_series_start ? '0 : r_held_req;
    assign ach_base  = i_series_start ? '0 : r_held_ach;

    // The difference of two 32-bit signed flows has a magnitude below 2^32.
    assign diff     = {req_base[sos_pkg::FLOW_W-1], req_base}
                    - {ach_base[sos_pkg::FLOW_W-1], ach_base};
    assign diff_neg = -diff;
    assign gap      = diff[sos_pkg::FLOW_W] ? diff_neg[sos_pkg::FLOW_W-1:0]
                                            : diff[sos_pkg::FLOW_W-1:0];

    assign time_zero = (i_sample_time == '0);
    assign late      = !time_zero && (i_sample_time <= prev_base);
    assign apply     = !time_zero && !late;

    always_comb begin
        n_prev_time = r_prev_time;
        n_held_req  = r_held_req;
        n_held_ach  = r_held_ach;
        if (accept) begin
            n_prev_time = apply ? i_sample_time : prev_base;
            n_held_req  = late ? req_base : i_requested_flow;
            n_held_ach  = late ? ach_base : i_achieved_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_tolerance <= sos_pkg::GAP_TOL_RESET;
            r_prev_time     <= '0;
            r_held_req      <= '0;
            r_held_ach      <= '0;
            r_valid         <= 1'b0;
            r_ctl           <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap_tolerance <= i_cfg_wr_data;
            end
            r_prev_time <= n_prev_time;
            r_held_req  <= n_held_req;
            r_held_ach  <= n_held_ach;
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_ctl.apply <= apply;
                r_ctl.clr   <= i_series_start;
                r_ctl.err   <= late;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dt      <= i_sample_time - prev_base;
            r_gap     <= gap;
            r_out_ach <= ach_base;
        end
    end

    assign o_valid         = r_valid;
    assign o_dt            = r_dt;
    assign o_gap           = r_gap;
    assign o_held_ach      = r_out_ach;
    assign o_ctl           = r_ctl;
    assign o_gap_tolerance = r_gap_tolerance;

endmodule

/* rtl/sos_mult.sv */
// Product stage: unserved and delivered energy of one interval and the outage decision.
`timescale 1ns / 1ps

module sos_mult (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sos_pkg::TIME_W-1:0]          i_dt,
    input  logic [sos_pkg::FLOW_W-1:0]          i_gap,
    input  logic signed [sos_pkg::FLOW_W-1:0]   i_held_ach,
    input  sos_pkg::t_ctl                       i_ctl,
    input  logic [sos_pkg::TOL_W-1:0]           i_gap_tolerance,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sos_pkg::SERV_W-1:0]          o_lost,
    output logic signed [sos_pkg::SERV_W-1:0]   o_served,
    output logic                                o_down,
    output logic [sos_pkg::TIME_W-1:0]          o_dt,
    output sos_pkg::t_ctl                       o_ctl
);

    logic                               r_valid;
    logic [sos_pkg::SERV_W-1:0]         r_lost;
    logic signed [sos_pkg::SERV_W-1:0]  r_served;
    logic                               r_down;
    logic [sos_pkg::TIME_W-1:0]         r_dt;
    sos_pkg::t_ctl                      r_ctl;

    logic                               load;
    logic [sos_pkg::SERV_W-1:0]         gap_ext;
    logic [sos_pkg::SERV_W-1:0]         dt_ext;
    logic signed [sos_pkg::SERV_W-1:0]  ach_ext;
    logic signed [sos_pkg::SERV_W-1:0]  dt_s;
    logic [sos_pkg::SERV_W-1:0]         lost;
    logic signed [sos_pkg::SERV_W-1:0]  served;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // The upper halves are pure zero or sign extension, so each product is 32 by 32.
    assign gap_ext = {{(sos_pkg::SERV_W-sos_pkg::FLOW_W){1'b0}}, i_gap};
    assign dt_ext  = {{(sos_pkg::SERV_W-sos_pkg::TIME_W){1'b0}}, i_dt};
    assign ach_ext = {{(sos_pkg::SERV_W-sos_pkg::FLOW_W){i_held_ach[sos_pkg::FLOW_W-1]}},
                      i_held_ach};
    assign dt_s    = signed'(dt_ext);

    // Gap times interval is below 2^64; held flow times interval is below 2^63 in magnitude.
    assign lost   = gap_ext * dt_ext;
    assign served = ach_ext * dt_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_ctl <= i_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lost   <= lost;
            r_served <= served;
            r_down   <= (i_gap > {1'b0, i_gap_tolerance});
            r_dt     <= i_dt;
        end
    end

    assign o_valid  = r_valid;
    assign o_lost   = r_lost;
    assign o_served = r_served;
    assign o_down   = r_down;
    assign o_dt     = r_dt;
    assign o_ctl    = r_ctl;

endmodule

/* rtl/sos_accum.sv */
// Result stage: time counters, outage tracking and saturating energy sums.
`timescale 1ns / 1ps

module sos_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sos_pkg::SERV_W-1:0]          i_lost,
    input  logic signed [sos_pkg::SERV_W-1:0]   i_served,
    input  logic                                i_down,
    input  logic [sos_pkg::TIME_W-1:0]          i_dt,
    input  sos_pkg::t_ctl                       i_ctl,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sos_pkg::TIME_W-1:0]          o_uptime_total,
    output logic [sos_pkg::TIME_W-1:0]          o_downtime_total,
    output logic [sos_pkg::TIME_W-1:0]          o_longest_outage,
    output logic [sos_pkg::LOST_W-1:0]          o_unserved_energy,
    output logic signed [sos_pkg::SERV_W-1:0]   o_delivered_energy,
    output logic                                o_order_error
);

    logic                               r_valid;
    logic [sos_pkg::TIME_W-1:0]         r_up, n_up;
    logic [sos_pkg::TIME_W-1:0]         r_down, n_down;
    logic [sos_pkg::TIME_W-1:0]         r_closed, n_closed;
    logic [sos_pkg::TIME_W-1:0]         r_cur, n_cur;
    logic                               r_in_out, n_in_out;
    logic [sos_pkg::LOST_W-1:0]         r_lost, n_lost;
    logic signed [sos_pkg::SERV_W-1:0]  r_served, n_served;
    logic [sos_pkg::TIME_W-1:0]         r_longest, n_longest;
    logic                               r_err;

    logic                               load;
    logic [sos_pkg::LOST_W-1:0]         b_lost;
    logic signed [sos_pkg::SERV_W-1:0]  b_served;
    logic [sos_pkg::TIME_W-1:0]         b_closed;
    logic [sos_pkg::TIME_W-1:0]         b_cur;
    logic                               b_in_out;
    logic [sos_pkg::LOST_W+1:0]         lost_sum;
    logic signed [sos_pkg::SERV_W:0]    served_sum;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        b_closed   = i_ctl.clr ? '0 : r_closed;
        b_cur      = i_ctl.clr ? '0 : r_cur;
        b_in_out   = i_ctl.clr ? 1'b0 : r_in_out;
        b_lost     = i_ctl.clr ? '0 : r_lost;
        b_served   = i_ctl.clr ? '0 : r_served;
        n_up       = i_ctl.clr ? '0 : r_up;
        n_down     = i_ctl.clr ? '0 : r_down;
        n_closed   = b_closed;
        n_cur      = b_cur;
        n_in_out   = b_in_out;
        n_lost     = b_lost;
        n_served   = b_served;
        lost_sum   = {2'b00, b_lost} + {1'b0, i_lost};
        served_sum = {b_served[sos_pkg::SERV_W-1], b_served}
                   + {i_served[sos_pkg::SERV_W-1], i_served};
        if (i_ctl.apply) begin
            if (i_down) begin
                n_down   = n_down + i_dt;
                n_cur    = b_in_out ? b_cur + i_dt : i_dt;
                n_in_out = 1'b1;
            end else begin
                n_up     = n_up + i_dt;
                n_closed = (b_cur > b_closed) ? b_cur : b_closed;
                n_cur    = '0;
                n_in_out = 1'b0;
            end
            if (lost_sum > {2'b00, sos_pkg::UNSERVED_MAX}) begin
                n_lost = sos_pkg::UNSERVED_MAX;
            end else begin
                n_lost = lost_sum[sos_pkg::LOST_W-1:0];
            end
            if (served_sum[sos_pkg::SERV_W] != served_sum[sos_pkg::SERV_W-1]) begin
                n_served = served_sum[sos_pkg::SERV_W] ? sos_pkg::SERVED_MIN
                                                       : sos_pkg::SERVED_MAX;
            end else begin
                n_served = served_sum[sos_pkg::SERV_W-1:0];
            end
        end
        n_longest = (n_in_out && (n_cur > n_closed)) ? n_cur : n_closed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_up      <= '0;
            r_down    <= '0;
            r_closed  <= '0;
            r_cur     <= '0;
            r_in_out  <= 1'b0;
            r_lost    <= '0;
            r_served  <= '0;
            r_longest <= '0;
            r_err     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_up      <= n_up;
                r_down    <= n_down;
                r_closed  <= n_closed;
                r_cur     <= n_cur;
                r_in_out  <= n_in_out;
                r_lost    <= n_lost;
                r_served  <= n_served;
                r_longest <= n_longest;
                r_err     <= i_ctl.err;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_uptime_total     = r_up;
    assign o_downtime_total   = r_down;
    assign o_longest_outage   = r_longest;
    assign o_unserved_energy  = r_lost;
    assign o_delivered_energy = r_served;
    assign o_order_error      = r_err;

endmodule

/* rtl/supply_outage_statistics_top.sv */
// Top level of the supply outage statistics block: three-stage pipeline and checks.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------------------------
// input     i_valid / o_ready       i_sample_time, i_requested_flow,
//                                   i_achieved_flow, i_series_start
// result    o_valid / i_ready       o_uptime_total, o_downtime_total,
//                                   o_longest_outage, o_unserved_energy,
//                                   o_delivered_energy, o_order_error
// config    i_cfg_wr_en             i_cfg_wr_data (gap tolerance, Q15.16)
//
// One beat is accepted every cycle while o_ready is high; each result passes the input,
// product and result stage registers in that order after its input beat is accepted.
// The rate is set by the held-sample loop in the input stage.
// Reset is synchronous and active low; it clears all statistics and sets the tolerance to 66.
// A stalled result holds the last stage and ready is passed back combinationally, so
// o_ready drops only once all three stages hold a beat and i_ready is low.

module supply_outage_statistics_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sos_pkg::TOL_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sos_pkg::TIME_W-1:0]          i_sample_time,
    input  logic signed [sos_pkg::FLOW_W-1:0]   i_requested_flow,
    input  logic signed [sos_pkg::FLOW_W-1:0]   i_achieved_flow,
    input  logic                                i_series_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sos_pkg::TIME_W-1:0]          o_uptime_total,
    output logic [sos_pkg::TIME_W-1:0]          o_downtime_total,
    output logic [sos_pkg::TIME_W-1:0]          o_longest_outage,
    output logic [sos_pkg::LOST_W-1:0]          o_unserved_energy,
    output logic signed [sos_pkg::SERV_W-1:0]   o_delivered_energy,
    output logic                                o_order_error
);

    // Input stage to product stage.
    logic                               s1_valid;
    logic                               s1_ready;
    logic [sos_pkg::TIME_W-1:0]         s1_dt;
    logic [sos_pkg::FLOW_W-1:0]         s1_gap;
    logic signed [sos_pkg::FLOW_W-1:0]  s1_held_ach;
    sos_pkg::t_ctl                      s1_ctl;
    logic [sos_pkg::TOL_W-1:0]          gap_tolerance;

    // Product stage to result stage.
    logic                               s2_valid;
    logic                               s2_ready;
    logic [sos_pkg::SERV_W-1:0]         s2_lost;
    logic signed [sos_pkg::SERV_W-1:0]  s2_served;
    logic                               s2_down;
    logic [sos_pkg::TIME_W-1:0]         s2_dt;
    sos_pkg::t_ctl                      s2_ctl;

    // The input stage owns the held sample, so order errors and intervals are
    // resolved at the moment a beat is accepted, with no dependence on later stages.
    sos_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_time    (i_sample_time),
        .i_requested_flow (i_requested_flow),
        .i_achieved_flow  (i_achieved_flow),
        .i_series_start   (i_series_start),
        .o_valid          (s1_valid),
        .i_ready          (s1_ready),
        .o_dt             (s1_dt),
        .o_gap            (s1_gap),
        .o_held_ach       (s1_held_ach),
        .o_ctl            (s1_ctl),
        .o_gap_tolerance  (gap_tolerance)
    );

    // Two 32 by 32 products per beat, registered before accumulation.
    sos_mult u_mult (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s1_valid),
        .o_ready         (s1_ready),
        .i_dt            (s1_dt),
        .i_gap           (s1_gap),
        .i_held_ach      (s1_held_ach),
        .i_ctl           (s1_ctl),
        .i_gap_tolerance (gap_tolerance),
        .o_valid         (s2_valid),
        .i_ready         (s2_ready),
        .o_lost          (s2_lost),
        .o_served        (s2_served),
        .o_down          (s2_down),
        .o_dt            (s2_dt),
        .o_ctl           (s2_ctl)
    );

    // The statistics registers double as the result register.
    sos_accum u_accum (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (s2_valid),
        .o_ready            (s2_ready),
        .i_lost             (s2_lost),
        .i_served           (s2_served),
        .i_down             (s2_down),
        .i_dt               (s2_dt),
        .i_ctl              (s2_ctl),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_uptime_total     (o_uptime_total),
        .o_downtime_total   (o_downtime_total),
        .o_longest_outage   (o_longest_outage),
        .o_unserved_energy  (o_unserved_energy),
        .o_delivered_energy (o_delivered_energy),
        .o_order_error      (o_order_error)
    );

`ifndef SYNTH
    // Input backpressure only arises when every stage is full and the result is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && s1_valid && s2_valid))
        else $error("input stalled while the pipeline has room");

    // The longest outage is part of total downtime.
    a_longest_in_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_longest_outage <= o_downtime_total))
        else $error("longest outage exceeds downtime");

    // A rejected sample leaves the reported statistics unchanged.
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && s2_ready && s2_ctl.err) |=>
            ($stable(o_uptime_total) && $stable(o_downtime_total)
             && $stable(o_unserved_energy) && $stable(o_delivered_energy)))
        else $error("order error changed the statistics");
`endif

endmodule
